### rtl/sled_pkg.sv
// shared types and constants of the string literal escape decoder
`default_nettype none

package sled_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_UNTERM     = 2'd0;
  localparam logic [1:0] ERR_BAD_ESC    = 2'd1;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd2;
  localparam logic [1:0] ERR_BAD_HEX    = 2'd3;

  localparam logic [7:0]  ESC_CODE       = 8'd27;
  localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;

  // what follows the leading error and the flushed value
  typedef enum logic [1:0] {
    TAIL_NONE   = 2'd0,
    TAIL_END    = 2'd1,
    TAIL_DATA   = 2'd2,
    TAIL_UNTERM = 2'd3
  } tail_e;

  typedef struct packed {
    logic        err_v;
    logic [1:0]  err_code;
    logic        flush_v;
    logic        uni;
    logic [31:0] value;
    tail_e       tail;
    logic [7:0]  tail_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [1:0] error_code;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

### rtl/sled_in_if.sv
// source byte channel
`default_nettype none

interface sled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

`default_nettype wire

### rtl/sled_out_if.sv
// decoded result channel
`default_nettype none

interface sled_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output kind, output data_byte, output error_code,
                  output last, input ready);
  modport sink (input valid, input kind, input data_byte, input error_code,
                input last, output ready);
endinterface

`default_nettype wire

### rtl/sled_front.sv
// front end: byte classification, escape state and hex accumulation
`default_nettype none

module sled_front import sled_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] source_byte_i,
  output logic       in_ready_o,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_e;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_UPPER_U = 8'h55;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_E       = 8'h65;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_V       = 8'h76;
  localparam logic [7:0] CH_X       = 8'h78;

  mode_e       mode_q, mode_d;
  logic [3:0]  digits_q, digits_d;
  logic [31:0] acc_q, acc_d;
  logic        uni_q, uni_d;

  logic        accept;
  logic        plain;
  logic        flush;
  logic [31:0] flush_val;
  logic [4:0]  hd;
  logic [31:0] acc_shift;
  logic [3:0]  dec;
  cmd_t        cmd;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  always_comb begin
    cmd       = '0;
    cmd.tail  = TAIL_NONE;
    mode_d    = mode_q;
    digits_d  = digits_q;
    acc_d     = acc_q;
    uni_d     = uni_q;
    plain     = 1'b0;
    flush     = 1'b0;
    flush_val = acc_q;
    hd        = hex_digit(source_byte_i);
    acc_shift = {acc_q[27:0], hd[3:0]};
    dec       = digits_q - 4'd1;

    case (mode_q)
      MODE_ESCAPE: begin
        mode_d = MODE_PLAIN;
        case (source_byte_i)
          CH_QUOTE, CH_BSLASH, CH_PERCENT: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = source_byte_i;
          end
          CH_ZERO: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = 8'd0;
          end
          CH_A: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = 8'd7;
          end
          CH_B: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = 8'd8;
          end
          CH_E: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = ESC_CODE;
          end
          CH_F: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = 8'd12;
          end
          CH_N: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = 8'd10;
          end
          CH_R: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = 8'd13;
          end
          CH_T: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = 8'd9;
          end
          CH_V: begin
            cmd.tail      = TAIL_DATA;
            cmd.tail_byte = 8'd11;
          end
          CH_U: begin
            mode_d   = MODE_HEX;
            digits_d = 4'd4;
            acc_d    = '0;
            uni_d    = 1'b1;
          end
          CH_UPPER_U: begin
            mode_d   = MODE_HEX;
            digits_d = 4'd8;
            acc_d    = '0;
            uni_d    = 1'b1;
          end
          CH_X: begin
            mode_d   = MODE_HEX;
            digits_d = 4'd2;
            acc_d    = '0;
            uni_d    = 1'b0;
          end
          default: begin
            cmd.err_v    = 1'b1;
            cmd.err_code = ERR_BAD_ESC;
            if (source_byte_i == CH_NUL) begin
              cmd.tail = TAIL_UNTERM;
            end
          end
        endcase
      end
      MODE_HEX: begin
        if (digits_q == 4'd0) begin
          plain = 1'b1;
        end else if (source_byte_i == CH_QUOTE || source_byte_i == CH_NUL) begin
          cmd.err_v    = 1'b1;
          cmd.err_code = ERR_INCOMPLETE;
          flush        = 1'b1;
          cmd.tail     = TAIL_END;
          mode_d       = MODE_PLAIN;
          digits_d     = 4'd0;
        end else if (!hd[4]) begin
          cmd.err_v    = 1'b1;
          cmd.err_code = ERR_BAD_HEX;
          flush        = 1'b1;
          digits_d     = 4'd0;
          plain        = 1'b1;
        end else begin
          acc_d    = acc_shift;
          digits_d = dec;
          if (dec == 4'd0) begin
            flush     = 1'b1;
            flush_val = acc_shift;
            mode_d    = MODE_PLAIN;
          end
        end
      end
      default: plain = 1'b1;
    endcase

    if (plain) begin
      mode_d = MODE_PLAIN;
      case (source_byte_i)
        CH_QUOTE:  cmd.tail = TAIL_END;
        CH_CR:     cmd.tail = TAIL_NONE;
        CH_NUL:    cmd.tail = TAIL_UNTERM;
        CH_BSLASH: mode_d = MODE_ESCAPE;
        default: begin
          cmd.tail      = TAIL_DATA;
          cmd.tail_byte = source_byte_i;
        end
      endcase
    end

    cmd.value   = flush_val;
    cmd.uni     = uni_q;
    cmd.flush_v = flush && (!uni_q || flush_val <= MAX_CODE_POINT);
  end

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign push_o     = accept && (cmd.err_v || cmd.flush_v || cmd.tail != TAIL_NONE);
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PLAIN;
      digits_q <= '0;
      acc_q    <= '0;
      uni_q    <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
      uni_q    <= uni_d;
    end
  end

  a_digits_in_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digits_q != 4'd0) |-> (mode_q == MODE_HEX))
    else $error("hex digits pending outside hex mode");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o)
    else $error("command pushed into full queue");

endmodule

`default_nettype wire

### rtl/sled_fifo.sv
// command queue between front end and back end
`default_nettype none

module sled_fifo import sled_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic head_valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   count_q;

  assign full_o       = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

### rtl/sled_back.sv
// back end: expands one command into result transactions, utf-8 encoding
`default_nettype none

module sled_back import sled_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  input  cmd_t    head_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic       out_valid_q;
  result_t    res_q;
  logic [2:0] pos_q;

  logic [7:0]  fb [4];
  logic [2:0]  fb_n;
  logic [2:0]  err_n;
  logic [2:0]  tail_n;
  logic [2:0]  n;
  logic [2:0]  rel;
  logic [2:0]  trel;
  logic [31:0] v;
  result_t     item;
  logic        advance;

  always_comb begin
    v     = head_i.value;
    fb[0] = v[7:0];
    fb[1] = 8'h00;
    fb[2] = 8'h00;
    fb[3] = 8'h00;
    fb_n  = 3'd1;
    if (!head_i.uni || v <= 32'h0000_007F) begin
      fb_n = 3'd1;
    end else if (v <= 32'h0000_07FF) begin
      fb[0] = {3'b110, v[10:6]};
      fb[1] = {2'b10, v[5:0]};
      fb_n  = 3'd2;
    end else if (v <= 32'h0000_FFFF) begin
      fb[0] = {4'b1110, v[15:12]};
      fb[1] = {2'b10, v[11:6]};
      fb[2] = {2'b10, v[5:0]};
      fb_n  = 3'd3;
    end else begin
      fb[0] = {5'b11110, v[20:18]};
      fb[1] = {2'b10, v[17:12]};
      fb[2] = {2'b10, v[11:6]};
      fb[3] = {2'b10, v[5:0]};
      fb_n  = 3'd4;
    end
    if (!head_i.flush_v) begin
      fb_n = 3'd0;
    end

    err_n = {2'b00, head_i.err_v};
    case (head_i.tail)
      TAIL_END, TAIL_DATA: tail_n = 3'd1;
      TAIL_UNTERM:         tail_n = 3'd2;
      default:             tail_n = 3'd0;
    endcase
    n = err_n + fb_n + tail_n;

    rel  = pos_q - err_n;
    trel = rel - fb_n;
    item = '0;
    if (head_i.err_v && pos_q == 3'd0) begin
      item.kind       = KIND_ERROR;
      item.error_code = head_i.err_code;
    end else if (rel < fb_n) begin
      item.kind      = KIND_DATA;
      item.data_byte = fb[rel[1:0]];
    end else begin
      case (head_i.tail)
        TAIL_DATA: begin
          item.kind      = KIND_DATA;
          item.data_byte = head_i.tail_byte;
        end
        TAIL_UNTERM: begin
          if (trel == 3'd0) begin
            item.kind       = KIND_ERROR;
            item.error_code = ERR_UNTERM;
          end else begin
            item.kind = KIND_END;
          end
        end
        default: item.kind = KIND_END;
      endcase
    end
    item.last = (pos_q == n - 3'd1);
  end

  assign advance     = !out_valid_q || out_ready_i;
  assign pop_o       = advance && head_valid_i && item.last;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else if (advance) begin
      out_valid_q <= head_valid_i;
      if (head_valid_i) begin
        pos_q <= item.last ? 3'd0 : pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && head_valid_i) begin
      res_q <= item;
    end
  end

  a_pos_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != 3'd0) |-> head_valid_i)
    else $error("partial command without queue head");

  a_pos_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (pos_q < n))
    else $error("result position beyond command length");

  a_data_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind != KIND_DATA) |-> (res_q.data_byte == 8'h00))
    else $error("non-data result carries a data byte");

endmodule

`default_nettype wire

### rtl/string_literal_escape_decoder.sv
// top level of the string literal escape decoder
//
// byte_i takes the raw bytes of a string literal after its opening quote, one
// per transaction; result_o gives the decoded results (data byte, end of string
// or error report), with last set on the final result caused by one byte.
// Bytes that give no result (carriage return, backslash, an escape letter or
// hex digit that only starts or continues an escape) produce no transaction.
// The front end updates the escape state and pushes one command per byte that
// gives a result into a four-entry queue; the back end turns each command into
// one to six results, one per cycle while result_o is ready, through a
// registered output stage. With the queue empty, a byte's command is written
// into the queue and its first result is then registered into the output stage.
// byte_i takes one byte per cycle while each byte gives at most one result and
// result_o is ready; for a byte that gives more results, the queue absorbs the
// difference until it fills, when byte_i.ready drops.
// Reset clears the escape state, the queue and the output stage; the decoder
// then starts in plain text mode. A stalled result_o holds its transaction
// and stops the back end; byte_i keeps accepting until the queue is full.
`default_nettype none

module string_literal_escape_decoder import sled_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  sled_in_if.sink           byte_i,
  sled_out_if.source        result_o
);

  logic    full;
  logic    push;
  cmd_t    push_cmd;
  logic    head_valid;
  cmd_t    head;
  logic    pop;
  result_t res;

  sled_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (byte_i.valid),
    .source_byte_i (byte_i.source_byte),
    .in_ready_o    (byte_i.ready),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  sled_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  sled_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .result_o     (res)
  );

  assign result_o.kind       = res.kind;
  assign result_o.data_byte  = res.data_byte;
  assign result_o.error_code = res.error_code;
  assign result_o.last       = res.last;

endmodule

`default_nettype wire
